### sv/tts_pkg.sv
// Shared constants, codes and controller/datapath interface types for the terminal.
package tts_pkg;

    // Geometry limits
    localparam int MAX_COLS         = 128;
    localparam int MAX_VISIBLE_ROWS = 25;
    localparam int HISTORY_FACTOR   = 10;
    localparam int STORE_ROWS       = HISTORY_FACTOR * MAX_VISIBLE_ROWS;
    localparam int CELLS            = STORE_ROWS * MAX_COLS;

    // Internal widths
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(STORE_ROWS);
    localparam int CADDR_W = ROW_W + COL_W;
    localparam int ECW     = $clog2(MAX_COLS + 1);
    localparam int ERW     = $clog2(MAX_VISIBLE_ROWS + 1);

    // Port widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int DELTA_W    = 9;
    localparam int RROW_W     = 5;
    localparam int RCOL_W     = 7;
    localparam int GLYPH_W    = 7;
    localparam int CURSOR_W   = 7;
    localparam int VIEW_W     = 8;
    localparam int CODE_W     = 7;
    localparam int COLS_W     = 8;
    localparam int VROWS_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Signed view arithmetic width
    localparam int MV_W = ((ROW_W > DELTA_W) ? ROW_W : DELTA_W) + 2;

    // Reset values of the configuration registers
    localparam logic [COLS_W-1:0]  COLS_RESET  = 8'd80;
    localparam logic [VROWS_W-1:0] VROWS_RESET = 5'd24;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VISIBLE_ROWS = 2'd1;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [CODE_W-1:0] SPACE_CODE = 7'd32;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_MOVE,
        OP_CLEAR,
        OP_READ
    } op_t;

    // What the datapath needs after the execute step
    typedef enum logic [1:0] {
        EX_DONE,
        EX_SPACE,
        EX_SWEEP,
        EX_READ
    } exec_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SPACE,
        ST_SWEEP,
        ST_RADDR,
        ST_RWAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic space_wr;
        logic sweep_wr;
        logic rd_addr;
        logic rd_glyph;
        logic cfg_wr;
    } dp_cmd_t;

    typedef struct packed {
        exec_kind_t exec_kind;
        logic       sweep_last;
        logic       cfg_hit;
    } dp_stat_t;

endpackage

### sv/tts_ctrl.sv
// Sequencing state machine for the terminal: issues datapath commands per step.
module tts_ctrl
    import tts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     cfg_valid,
    input  dp_stat_t stat,
    output logic     busy,
    output logic     cfg_ready,
    output logic     done,
    output dp_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   report_reg, report_next;

    // State registers; reset enters the bottom-row sweep with no result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_SWEEP;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
                else if (cfg_valid && stat.cfg_hit)
                begin
                    state_next  = ST_SWEEP;
                    report_next = 1'b0;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                case (stat.exec_kind)
                    EX_SPACE: state_next = ST_SPACE;
                    EX_SWEEP:
                    begin
                        state_next  = ST_SWEEP;
                        report_next = 1'b1;
                    end
                    EX_READ:  state_next = ST_RADDR;
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_SPACE: state_next = ST_DONE;
            ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = report_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_RADDR: state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        busy         = !((state_reg == ST_IDLE) || (state_reg == ST_DONE));
        cfg_ready    = !busy && !start;
        done         = (state_reg == ST_DONE);
        cmd.latch_in = start && !busy;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.space_wr = (state_reg == ST_SPACE);
        cmd.sweep_wr = (state_reg == ST_SWEEP);
        cmd.rd_addr  = (state_reg == ST_RADDR);
        cmd.rd_glyph = (state_reg == ST_RWAIT);
        cmd.cfg_wr   = cfg_valid && cfg_ready;
    end

endmodule

### sv/tts_dpath.sv
// Terminal datapath: character store, row valid bits, cursor, view and geometry registers.
module tts_dpath
    import tts_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  dp_cmd_t                      cmd,
    output dp_stat_t                     stat,
    input  logic [OP_W-1:0]              operation,
    input  logic [CHAR_W-1:0]            char_code,
    input  logic signed [DELTA_W-1:0]    view_delta,
    input  logic [RROW_W-1:0]            read_row,
    input  logic [RCOL_W-1:0]            read_col,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    output logic [GLYPH_W-1:0]           glyph_index,
    output logic [CURSOR_W-1:0]          cursor_col,
    output logic [VIEW_W-1:0]            view_offset
);

    // Latched transaction fields
    op_t                      op_reg;
    logic [CHAR_W-1:0]        char_reg;
    logic signed [DELTA_W-1:0] delta_reg;
    logic [RROW_W-1:0]        rrow_reg;
    logic [RCOL_W-1:0]        rcol_reg;

    // Control state
    logic [COLS_W-1:0]     cols_cfg_reg, cols_cfg_next;
    logic [VROWS_W-1:0]    rows_cfg_reg, rows_cfg_next;
    logic [COL_W-1:0]      cursor_reg, cursor_next;
    logic [ROW_W-1:0]      vup_reg, vup_next;
    logic [ROW_W-1:0]      rb_reg, rb_next;
    logic [STORE_ROWS-1:0] row_valid_reg, row_valid_next;
    logic [COL_W-1:0]      sweep_col_reg, sweep_col_next;

    // Read pipeline and result
    logic [ROW_W-1:0]   logical_reg, logical_next;
    logic               oob_reg, oob_next;
    logic               rd_valid_reg;
    logic [CODE_W-1:0]  mem_rdata_reg;
    logic [GLYPH_W-1:0] glyph_reg, glyph_next;

    logic [CODE_W-1:0] mem [0:CELLS-1];

    // Derived geometry
    logic [ECW-1:0]   ec;
    logic [ERW-1:0]   er;
    logic [ROW_W-1:0] hist;
    logic [ROW_W-1:0] bottom;
    logic [ROW_W-1:0] rb_inc;
    logic [ROW_W-1:0] view_limit;

    // Execute-step decode
    exec_kind_t       kind;
    logic [COL_W-1:0] col_c;
    logic [ECW-1:0]   col_inc;
    logic             we_x;
    logic             scroll_x;
    logic [COL_W-1:0] wcol_x;
    logic [CODE_W-1:0] wdata_x;
    logic [COL_W-1:0] cur_x;
    logic [ROW_W-1:0] vup_x;
    logic signed [MV_W-1:0] mv_sum;
    logic             clear_x;

    // Memory write port and read address
    logic               mem_we;
    logic [COL_W-1:0]   mem_wcol;
    logic [CODE_W-1:0]  mem_wdata;
    logic [CADDR_W-1:0] mem_waddr;
    logic [ROW_W:0]     phys_sum;
    logic [ROW_W-1:0]   phys;
    logic [CADDR_W-1:0] mem_raddr;

    logic cfg_hit;

    // Effective geometry: zero acts as one, large values saturate
    always_comb
    begin
        if (cols_cfg_reg == '0)
        begin
            ec = ECW'(1);
        end
        else if (ECW'(cols_cfg_reg) > ECW'(MAX_COLS))
        begin
            ec = ECW'(MAX_COLS);
        end
        else
        begin
            ec = ECW'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0)
        begin
            er = ERW'(1);
        end
        else if (ERW'(rows_cfg_reg) > ERW'(MAX_VISIBLE_ROWS))
        begin
            er = ERW'(MAX_VISIBLE_ROWS);
        end
        else
        begin
            er = ERW'(rows_cfg_reg);
        end
        hist       = ROW_W'(er * HISTORY_FACTOR);
        view_limit = hist - ROW_W'(er);
        bottom     = (rb_reg == '0) ? hist - ROW_W'(1) : rb_reg - ROW_W'(1);
        rb_inc     = (rb_reg == hist - ROW_W'(1)) ? '0 : rb_reg + ROW_W'(1);
    end

    assign cfg_hit = (cfg_index == REG_COLUMNS) || (cfg_index == REG_VISIBLE_ROWS);

    // Decode of the latched transaction
    always_comb
    begin
        kind     = EX_DONE;
        we_x     = 1'b0;
        scroll_x = 1'b0;
        clear_x  = 1'b0;
        wdata_x  = SPACE_CODE;
        col_c    = ({1'b0, cursor_reg} >= ec) ? COL_W'(ec - ECW'(1)) : cursor_reg;
        col_inc  = ECW'(col_c) + ECW'(1);
        wcol_x   = col_c;
        cur_x    = cursor_reg;
        vup_x    = vup_reg;
        mv_sum   = signed'(MV_W'(vup_reg)) + MV_W'(delta_reg);
        case (op_reg)
            OP_PUT:
            begin
                if (char_reg == CHAR_NUL)
                begin
                    kind = EX_DONE;
                end
                else if (char_reg == CHAR_CR)
                begin
                    wcol_x = '0;
                    we_x   = 1'b1;
                    cur_x  = '0;
                end
                else if (char_reg == CHAR_LF)
                begin
                    we_x     = 1'b1;
                    cur_x    = '0;
                    scroll_x = 1'b1;
                    kind     = EX_SWEEP;
                end
                else if (char_reg == CHAR_BS)
                begin
                    wcol_x = (col_c == '0) ? '0 : col_c - COL_W'(1);
                    we_x   = 1'b1;
                    cur_x  = wcol_x;
                end
                else if ((char_reg >= PRINT_LO) && !char_reg[CHAR_W-1])
                begin
                    // printable: store it, then blank the next cell or scroll on wrap
                    wdata_x = char_reg[CODE_W-1:0];
                    we_x    = 1'b1;
                    if (col_inc >= ec)
                    begin
                        cur_x    = '0;
                        scroll_x = 1'b1;
                        kind     = EX_SWEEP;
                    end
                    else
                    begin
                        cur_x = col_inc[COL_W-1:0];
                        kind  = EX_SPACE;
                    end
                end
                else
                begin
                    we_x  = 1'b1;
                    cur_x = col_c;
                end
            end
            OP_MOVE:
            begin
                if (mv_sum < 0)
                begin
                    vup_x = '0;
                end
                else if (mv_sum >= signed'(MV_W'(view_limit)))
                begin
                    vup_x = view_limit - ROW_W'(1);
                end
                else
                begin
                    vup_x = mv_sum[ROW_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                clear_x = 1'b1;
                kind    = EX_SWEEP;
            end
            OP_READ:
            begin
                kind = EX_READ;
            end
            default:
            begin
                kind = EX_DONE;
            end
        endcase
    end

    // Status back to the controller
    always_comb
    begin
        stat.exec_kind  = kind;
        stat.sweep_last = (sweep_col_reg == COL_W'(ec - ECW'(1)));
        stat.cfg_hit    = cfg_hit;
    end

    // Next values of control state and read pipeline
    always_comb
    begin
        cols_cfg_next  = cols_cfg_reg;
        rows_cfg_next  = rows_cfg_reg;
        cursor_next    = cursor_reg;
        vup_next       = vup_reg;
        rb_next        = rb_reg;
        row_valid_next = row_valid_reg;
        sweep_col_next = sweep_col_reg;
        logical_next   = logical_reg;
        oob_next       = oob_reg;
        glyph_next     = glyph_reg;

        if (cmd.exec)
        begin
            glyph_next  = '0;
            cursor_next = cur_x;
            vup_next    = vup_x;
            if (scroll_x)
            begin
                rb_next = rb_inc;
            end
            // view window top plus the requested row
            oob_next = (ERW'(rrow_reg) >= er) || (ECW'(rcol_reg) >= ec);
            if (oob_next)
            begin
                logical_next = '0;
            end
            else
            begin
                logical_next = hist - ROW_W'(er) - vup_reg + ROW_W'(rrow_reg);
            end
        end

        // Clear cursor, view, row base and row valid bits, from the clear operation or a listed register write
        if ((cmd.exec && clear_x) || (cmd.cfg_wr && cfg_hit))
        begin
            cursor_next    = '0;
            vup_next       = '0;
            rb_next        = '0;
            row_valid_next = '0;
        end
        if (cmd.cfg_wr && (cfg_index == REG_COLUMNS))
        begin
            cols_cfg_next = cfg_data[COLS_W-1:0];
        end
        if (cmd.cfg_wr && (cfg_index == REG_VISIBLE_ROWS))
        begin
            rows_cfg_next = cfg_data[VROWS_W-1:0];
        end

        // Row sweep: blank the bottom row one cell a cycle
        if (cmd.sweep_wr)
        begin
            row_valid_next[bottom] = 1'b1;
            sweep_col_next = stat.sweep_last ? '0 : sweep_col_reg + COL_W'(1);
        end

        // Glyph from the registered store word
        if (cmd.rd_glyph)
        begin
            if (oob_reg || !rd_valid_reg || (mem_rdata_reg < SPACE_CODE))
            begin
                glyph_next = '0;
            end
            else
            begin
                glyph_next = GLYPH_W'(mem_rdata_reg - SPACE_CODE);
            end
        end
    end

    // Store write port and read address
    always_comb
    begin
        mem_we    = (cmd.exec && we_x) || cmd.space_wr || cmd.sweep_wr;
        mem_wcol  = cmd.sweep_wr ? sweep_col_reg : (cmd.space_wr ? cursor_reg : wcol_x);
        mem_wdata = cmd.exec ? wdata_x : SPACE_CODE;
        mem_waddr = {bottom, mem_wcol};
        phys_sum  = {1'b0, rb_reg} + {1'b0, logical_reg};
        phys      = (phys_sum >= {1'b0, hist}) ? ROW_W'(phys_sum - {1'b0, hist})
                                                : phys_sum[ROW_W-1:0];
        mem_raddr = {phys, COL_W'(rcol_reg)};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg  <= COLS_RESET;
            rows_cfg_reg  <= VROWS_RESET;
            cursor_reg    <= '0;
            vup_reg       <= '0;
            rb_reg        <= '0;
            row_valid_reg <= '0;
            sweep_col_reg <= '0;
        end
        else
        begin
            cols_cfg_reg  <= cols_cfg_next;
            rows_cfg_reg  <= rows_cfg_next;
            cursor_reg    <= cursor_next;
            vup_reg       <= vup_next;
            rb_reg        <= rb_next;
            row_valid_reg <= row_valid_next;
            sweep_col_reg <= sweep_col_next;
        end
    end

    // Transaction latch and read pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= op_t'(operation);
            char_reg  <= char_code;
            delta_reg <= view_delta;
            rrow_reg  <= read_row;
            rcol_reg  <= read_col;
        end
        logical_reg <= logical_next;
        oob_reg     <= oob_next;
        glyph_reg   <= glyph_next;
        if (cmd.rd_addr)
        begin
            rd_valid_reg <= row_valid_reg[phys];
        end
    end

    // Character store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_addr)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign glyph_index = glyph_reg;
    assign cursor_col  = CURSOR_W'(cursor_reg);
    assign view_offset = VIEW_W'(vup_reg);

endmodule

### sv/text_terminal_scrollback.sv
// Top level of the text terminal with scrollback: controller plus datapath.
//
// Channel   Signals                                          Transaction when
// item      start, busy, operation, char_code, view_delta,   start && !busy
//           read_row, read_col
// result    done, glyph_index, cursor_col, view_offset       done (one cycle)
// config    cfg_valid, cfg_ready, cfg_index, cfg_data        cfg_valid && cfg_ready
//
// From accept to done: move, CR, BS and ignored codes pass the execute step only; a printable
// character also blanks the next cell, a read adds the address and wait states (store read
// is registered), and an item that scrolls or clears blanks the new bottom row one cell a cycle
// on the single store write port. A new item may be accepted in the done cycle.
// After reset, and after a config write to a listed register, the bottom row is
// blanked cell by cell across the configured columns with busy high and no result.
// The receiver cannot stall: each result is shown for exactly one cycle.
module text_terminal_scrollback
    import tts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            operation,
    input  logic [CHAR_W-1:0]          char_code,
    input  logic signed [DELTA_W-1:0]  view_delta,
    input  logic [RROW_W-1:0]          read_row,
    input  logic [RCOL_W-1:0]          read_col,
    output logic                       done,
    output logic [GLYPH_W-1:0]         glyph_index,
    output logic [CURSOR_W-1:0]        cursor_col,
    output logic [VIEW_W-1:0]          view_offset,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer
    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .stat      (stat),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done),
        .cmd       (cmd)
    );

    // Store and registers
    tts_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .char_code   (char_code),
        .view_delta  (view_delta),
        .read_row    (read_row),
        .read_col    (read_col),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .glyph_index (glyph_index),
        .cursor_col  (cursor_col),
        .view_offset (view_offset)
    );

endmodule

### sv/tts_checker.sv
// Port-level checker for the terminal, bound to the top level.
module tts_checker
    import tts_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [GLYPH_W-1:0]    glyph_index,
    input logic [VIEW_W-1:0]     view_offset,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index
);

    // Every item passes the execute state before done, so strobes never touch
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe in consecutive cycles");

    // An accepted transaction keeps the block busy in the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after accepted transaction");

    // A listed register write starts the row sweep
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == REG_COLUMNS ||
                                    cfg_index == REG_VISIBLE_ROWS)) |=> busy)
        else $error("register write did not start the sweep");

    // Glyphs cover codes 32 to 127 only
    a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (glyph_index <= GLYPH_W'(95)))
        else $error("glyph index out of range");

    // The view never leaves the stored history
    a_view_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (view_offset < VIEW_W'(STORE_ROWS)))
        else $error("view offset out of range");

endmodule

bind text_terminal_scrollback tts_checker u_tts_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .glyph_index (glyph_index),
    .view_offset (view_offset),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index)
);
